// ===== design/mbet_pkg.sv =====
`default_nettype none
package mbet_pkg;

    localparam int Q_W      = 32;
    localparam int STEP_W   = 24;
    localparam int COUNT_W  = 12;
    localparam int RADIUS_W = 7;
    localparam int IDX_W    = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COLOUR_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_RE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IM  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_IM    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ  = 3'd5;

    typedef struct packed {
        logic signed [Q_W-1:0] origin_re;
        logic signed [Q_W-1:0] origin_im;
        logic [STEP_W-1:0]     step_re;
        logic [STEP_W-1:0]     step_im;
        logic [COUNT_W-1:0]    iteration_limit;
        logic [RADIUS_W-1:0]   escape_radius_sq;
    } mbet_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COORD_MUL,
        ST_COORD_ADD,
        ST_SQUARE,
        ST_UPDATE,
        ST_FINISH
    } mbet_state_t;

    typedef struct packed {
        logic capture;
        logic coord_mul;
        logic coord_add;
        logic square;
        logic step_z;
        logic load_result;
    } mbet_cmd_t;

    typedef struct packed {
        logic limit_hit;
        logic escape;
    } mbet_status_t;

endpackage
`default_nettype wire

// ===== design/mbet_regs.sv =====
`default_nettype none
module mbet_regs
    import mbet_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output mbet_cfg_t                  cfg
);

    mbet_cfg_t cfg_reg;
    mbet_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ORIGIN_RE:  cfg_next.origin_re        = cfg_data;
                REG_ORIGIN_IM:  cfg_next.origin_im        = cfg_data;
                REG_STEP_RE:    cfg_next.step_re          = cfg_data[STEP_W-1:0];
                REG_STEP_IM:    cfg_next.step_im          = cfg_data[STEP_W-1:0];
                REG_ITER_LIMIT: cfg_next.iteration_limit  = cfg_data[COUNT_W-1:0];
                REG_RADIUS_SQ:  cfg_next.escape_radius_sq = cfg_data[RADIUS_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_re        <= -32'sd33554432;
            cfg_reg.origin_im        <= -32'sd25165824;
            cfg_reg.step_re          <= 24'd62915;
            cfg_reg.step_im          <= 24'd62915;
            cfg_reg.iteration_limit  <= 12'd256;
            cfg_reg.escape_radius_sq <= 7'd100;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/mbet_ctrl.sv =====
`default_nettype none
module mbet_ctrl
    import mbet_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  wire logic   out_stall,
    input  wire mbet_status_t status,
    output mbet_cmd_t   cmd
);

    mbet_state_t state_reg;
    mbet_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        slot_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_COORD_MUL;
                end
            end
            ST_COORD_MUL:
            begin
                cmd.coord_mul = 1'b1;
                state_next    = ST_COORD_ADD;
            end
            ST_COORD_ADD:
            begin
                cmd.coord_add = 1'b1;
                state_next    = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (status.limit_hit || status.escape)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.step_z = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_FINISH:
            begin
                // wait here while the previous result is still held
                if (slot_free)
                begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/mbet_dpath.sv =====
`default_nettype none
module mbet_dpath
    import mbet_pkg::*;
#(
    parameter int GRID_SIZE = 1024
)
(
    input  wire logic              clk,
    input  wire mbet_cfg_t         cfg,
    input  wire mbet_cmd_t         cmd,
    output mbet_status_t           status,
    input  wire logic [IDX_W-1:0]  column,
    input  wire logic [IDX_W-1:0]  row,
    output logic [IDX_W-1:0]       out_column,
    output logic [IDX_W-1:0]       out_row,
    output logic                   escaped,
    output logic [COUNT_W-1:0]     iteration_count,
    output logic [COLOUR_W-1:0]    red,
    output logic [COLOUR_W-1:0]    green,
    output logic [COLOUR_W-1:0]    blue
);

    localparam int PROD_W    = IDX_W + STEP_W;
    localparam int SUM_W     = 42;
    localparam int SQ_W      = 2 * Q_W;
    localparam int FRAC      = 24;
    localparam int IDX_CMP_W = 13;
    localparam logic [IDX_CMP_W-1:0] GridLast = IDX_CMP_W'(GRID_SIZE - 1);

    function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] idx);
        if ({{(IDX_CMP_W-IDX_W){1'b0}}, idx} > GridLast)
            return GridLast[IDX_W-1:0];
        else
            return idx;
    endfunction

    function automatic logic [Q_W-1:0] sat_q(input logic [SUM_W-1:0] v);
        if (v[SUM_W-1:Q_W-1] == '0 || v[SUM_W-1:Q_W-1] == '1)
            return v[Q_W-1:0];
        else if (v[SUM_W-1])
            return {1'b1, {(Q_W-1){1'b0}}};
        else
            return {1'b0, {(Q_W-1){1'b1}}};
    endfunction

    logic [IDX_W-1:0]        col_reg;
    logic [IDX_W-1:0]        row_reg;
    logic [PROD_W-1:0]       prod_re_reg;
    logic [PROD_W-1:0]       prod_im_reg;
    logic signed [Q_W-1:0]   c_re_reg;
    logic signed [Q_W-1:0]   c_im_reg;
    logic signed [Q_W-1:0]   x_reg;
    logic signed [Q_W-1:0]   y_reg;
    logic signed [SQ_W-1:0]  xx_reg;
    logic signed [SQ_W-1:0]  yy_reg;
    logic signed [SQ_W-1:0]  xy_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic [IDX_W-1:0]        out_column_reg;
    logic [IDX_W-1:0]        out_row_reg;
    logic                    escaped_reg;
    logic [COUNT_W-1:0]      count_out_reg;
    logic [COLOUR_W-1:0]     red_reg;
    logic [COLOUR_W-1:0]     green_reg;

    logic [Q_W-1:0]          c_re_next;
    logic [Q_W-1:0]          c_im_next;
    logic [SQ_W-1:0]         mag;
    logic [SQ_W-1:0]         threshold;
    logic signed [SQ_W-1:0]  diff;
    logic [SUM_W-1:0]        re_sum;
    logic [SUM_W-1:0]        im_sum;
    logic                    esc_now;
    logic [COLOUR_W-1:0]     cnt8;
    logic [COLOUR_W-1:0]     red_next;

    always_comb
    begin
        c_re_next = sat_q({{(SUM_W-Q_W){cfg.origin_re[Q_W-1]}}, cfg.origin_re}
                          + {{(SUM_W-PROD_W){1'b0}}, prod_re_reg});
        c_im_next = sat_q({{(SUM_W-Q_W){cfg.origin_im[Q_W-1]}}, cfg.origin_im}
                          + {{(SUM_W-PROD_W){1'b0}}, prod_im_reg});
        // squares are non-negative, so the unsigned sum cannot wrap
        mag       = $unsigned(xx_reg) + $unsigned(yy_reg);
        threshold = {{(SQ_W-RADIUS_W-2*FRAC){1'b0}}, cfg.escape_radius_sq, {(2*FRAC){1'b0}}};
        diff      = xx_reg - yy_reg;
        // arithmetic shifts of the products give floor division
        re_sum    = {{(SUM_W-(SQ_W-FRAC)){diff[SQ_W-1]}}, diff[SQ_W-1:FRAC]}
                    + {{(SUM_W-Q_W){c_re_reg[Q_W-1]}}, c_re_reg};
        im_sum    = {{(SUM_W-(SQ_W-FRAC+1)){xy_reg[SQ_W-1]}}, xy_reg[SQ_W-1:FRAC-1]}
                    + {{(SUM_W-Q_W){c_im_reg[Q_W-1]}}, c_im_reg};
        status.limit_hit = (count_reg >= cfg.iteration_limit);
        status.escape    = (mag > threshold);
        esc_now   = !status.limit_hit && status.escape;
        cnt8      = count_reg[COLOUR_W-1:0];
        red_next  = (cnt8 << 3) + (cnt8 << 1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            col_reg <= column;
            row_reg <= row;
        end
        if (cmd.coord_mul)
        begin
            prod_re_reg <= PROD_W'(clamp_idx(col_reg)) * PROD_W'(cfg.step_re);
            prod_im_reg <= PROD_W'(clamp_idx(row_reg)) * PROD_W'(cfg.step_im);
        end
        if (cmd.coord_add)
        begin
            c_re_reg  <= c_re_next;
            c_im_reg  <= c_im_next;
            x_reg     <= c_re_next;
            y_reg     <= c_im_next;
            count_reg <= '0;
        end
        if (cmd.square)
        begin
            xx_reg <= x_reg * x_reg;
            yy_reg <= y_reg * y_reg;
            xy_reg <= x_reg * y_reg;
        end
        if (cmd.step_z)
        begin
            x_reg     <= sat_q(re_sum);
            y_reg     <= sat_q(im_sum);
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.load_result)
        begin
            out_column_reg <= col_reg;
            out_row_reg    <= row_reg;
            escaped_reg    <= esc_now;
            count_out_reg  <= count_reg;
            red_reg        <= esc_now ? red_next : '0;
            green_reg      <= esc_now ? cnt8 : '0;
        end
    end

    assign out_column      = out_column_reg;
    assign out_row         = out_row_reg;
    assign escaped         = escaped_reg;
    assign iteration_count = count_out_reg;
    assign red             = red_reg;
    assign green           = green_reg;
    assign blue            = green_reg;

endmodule
`default_nettype wire

// ===== design/mandelbrot_escape_time_core.sv =====
`default_nettype none
// Escape-time evaluator for one pixel at a time: a request carries a grid column and row,
// c is formed as origin + index*step in signed Q8.24 (saturated, index clamped to the grid),
// and z = z^2 + c is iterated from z = c until |z|^2 exceeds the escape radius squared or the
// iteration limit is reached. A pixel goes through the multiply and the add that form c, then
// one pass of the square-and-update loop per step (three 32x32 multipliers, then the add,
// compare and saturate) with one extra pass for the final check, then the hand-over of the
// result and the return to idle. The result sits in an output register, so the next request
// is taken while an earlier result is still stalled. Configuration is written through a
// separate port that is always ready and must only be used while the core is idle.
module mandelbrot_escape_time_core
    import mbet_pkg::*;
#(
    parameter int GRID_SIZE = 1024
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [IDX_W-1:0]      column,
    input  wire logic [IDX_W-1:0]      row,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [IDX_W-1:0]           out_column,
    output logic [IDX_W-1:0]           out_row,
    output logic                       escaped,
    output logic [COUNT_W-1:0]         iteration_count,
    output logic [COLOUR_W-1:0]        red,
    output logic [COLOUR_W-1:0]        green,
    output logic [COLOUR_W-1:0]        blue
);

    mbet_cfg_t    cfg;
    mbet_cmd_t    cmd;
    mbet_status_t status;

    mbet_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbet_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mbet_dpath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_dpath (
        .clk             (clk),
        .cfg             (cfg),
        .cmd             (cmd),
        .status          (status),
        .column          (column),
        .row             (row),
        .out_column      (out_column),
        .out_row         (out_row),
        .escaped         (escaped),
        .iteration_count (iteration_count),
        .red             (red),
        .green           (green),
        .blue            (blue)
    );

    // one pixel in flight: the cycle after a request is taken the input is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second request taken while a pixel is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (iteration_count <= cfg.iteration_limit))
        else $error("iteration count beyond limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !escaped) |-> (red == '0 && green == '0 && blue == '0))
        else $error("colour on a pixel that did not escape");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && escaped) |-> (green == iteration_count[COLOUR_W-1:0] && blue == green))
        else $error("colour does not follow iteration count");

endmodule
`default_nettype wire

// ===== dv/mandelbrot_escape_time_checker.sv =====
module mandelbrot_escape_time_checker
    import mbet_pkg::*;
#(
    parameter int GRID_SIZE = 1024
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic [IDX_W-1:0]      column,
    input  wire logic [IDX_W-1:0]      row,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic [IDX_W-1:0]      out_column,
    input  wire logic [IDX_W-1:0]      out_row,
    input  wire logic                  escaped,
    input  wire logic [COUNT_W-1:0]    iteration_count,
    input  wire logic [COLOUR_W-1:0]   red,
    input  wire logic [COLOUR_W-1:0]   green,
    input  wire logic [COLOUR_W-1:0]   blue,
    output int                         fail_count,
    output int                         pending,
    output int                         pixel_total,
    output int                         escaped_total
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;

    localparam mbet_cfg_t PLANE_AT_RESET = '{
        origin_re:        32'shFE000000,
        origin_im:        32'shFE800000,
        step_re:          24'd62915,
        step_im:          24'd62915,
        iteration_limit:  12'd256,
        escape_radius_sq: 7'd100
    };

    typedef struct packed {
        logic [IDX_W-1:0]    column;
        logic [IDX_W-1:0]    row;
        logic                escaped;
        logic [COUNT_W-1:0]  count;
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
    } pixel_result_t;

    mbet_cfg_t     plane;
    pixel_result_t awaited_pixels[$];

    function automatic longint clamp_q(input longint v);
        if (v > Q_HI)
            return Q_HI;
        if (v < Q_LO)
            return Q_LO;
        return v;
    endfunction

    function automatic longint grid_point(input logic signed [Q_W-1:0] origin,
                                          input logic [STEP_W-1:0]     stride,
                                          input logic [IDX_W-1:0]      index);
        longint pos;
        pos = longint'(index);
        if (pos > GRID_SIZE - 1)
            pos = GRID_SIZE - 1;
        return clamp_q(longint'(origin) + pos * longint'(stride));
    endfunction

    function automatic pixel_result_t predict_escape(input logic [IDX_W-1:0] col,
                                                     input logic [IDX_W-1:0] rw);
        longint        c_re;
        longint        c_im;
        longint        x;
        longint        y;
        longint        xx;
        longint        yy;
        longint        xy;
        logic [63:0]   mag;
        logic [63:0]   bound;
        int unsigned   steps;
        bit            esc;
        pixel_result_t r;
        c_re  = grid_point(plane.origin_re, plane.step_re, col);
        c_im  = grid_point(plane.origin_im, plane.step_im, rw);
        x     = c_re;
        y     = c_im;
        bound = 64'(plane.escape_radius_sq) << 48;
        steps = 0;
        esc   = 1'b0;
        while (!esc && steps < plane.iteration_limit)
        begin
            xx  = x * x;
            yy  = y * y;
            xy  = x * y;
            // sum can reach 2^63, so the compare is done on the raw bits
            mag = xx + yy;
            if (mag > bound)
                esc = 1'b1;
            else
            begin
                x = clamp_q(((xx - yy) >>> 24) + c_re);
                y = clamp_q((xy >>> 23) + c_im);
                steps++;
            end
        end
        r.column  = col;
        r.row     = rw;
        r.escaped = esc;
        r.count   = steps[COUNT_W-1:0];
        // pixels that stay bounded are not painted
        r.red     = esc ? 8'(steps * 10) : '0;
        r.green   = esc ? 8'(steps) : '0;
        r.blue    = esc ? 8'(steps) : '0;
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t want;
        if (!rst_n)
        begin
            plane = PLANE_AT_RESET;
            awaited_pixels.delete();
            fail_count    = 0;
            pending       = 0;
            pixel_total   = 0;
            escaped_total = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ORIGIN_RE:  plane.origin_re        = cfg_data;
                    REG_ORIGIN_IM:  plane.origin_im        = cfg_data;
                    REG_STEP_RE:    plane.step_re          = cfg_data[STEP_W-1:0];
                    REG_STEP_IM:    plane.step_im          = cfg_data[STEP_W-1:0];
                    REG_ITER_LIMIT: plane.iteration_limit  = cfg_data[COUNT_W-1:0];
                    REG_RADIUS_SQ:  plane.escape_radius_sq = cfg_data[RADIUS_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                pixel_total++;
                if (escaped)
                    escaped_total++;
                if (awaited_pixels.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result for column %0d row %0d, expected none, none waiting",
                             $time, out_column, out_row);
                end
                else
                begin
                    want = awaited_pixels.pop_front();
                    compare_field("out_column", want.column, out_column);
                    compare_field("out_row", want.row, out_row);
                    compare_field("escaped", want.escaped, escaped);
                    compare_field("iteration_count", want.count, iteration_count);
                    compare_field("red", want.red, red);
                    compare_field("green", want.green, green);
                    compare_field("blue", want.blue, blue);
                end
            end
            if (in_valid && !in_stall)
                awaited_pixels.push_back(predict_escape(column, row));
            pending = awaited_pixels.size();
        end
    end

endmodule

// ===== dv/mandelbrot_escape_time_core_tb.sv =====
module mandelbrot_escape_time_core_tb
    import mbet_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID           = 1024;
    localparam int PHASES         = 13;
    localparam int PIXELS_PER_SET = 100;
    localparam int WATCHDOG_LIMIT = 50000;

    // indexes past the last register, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [IDX_W-1:0]      column     = '0;
    logic [IDX_W-1:0]      row        = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [IDX_W-1:0]      out_column;
    logic [IDX_W-1:0]      out_row;
    logic                  escaped;
    logic [COUNT_W-1:0]    iteration_count;
    logic [COLOUR_W-1:0]   red;
    logic [COLOUR_W-1:0]   green;
    logic [COLOUR_W-1:0]   blue;

    int          fail_count;
    int          pending;
    int          pixel_total;
    int          escaped_total;
    int unsigned send_idle_pct = 38;
    int unsigned stall_pct     = 78;
    int          plane_changes = 0;
    int          quiet_cycles  = 0;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    mandelbrot_escape_time_core #(
        .GRID_SIZE(GRID)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .column(column),
        .row(row),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_column(out_column),
        .out_row(out_row),
        .escaped(escaped),
        .iteration_count(iteration_count),
        .red(red),
        .green(green),
        .blue(blue)
    );

    mandelbrot_escape_time_checker #(
        .GRID_SIZE(GRID)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .column(column),
        .row(row),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_column(out_column),
        .out_row(out_row),
        .escaped(escaped),
        .iteration_count(iteration_count),
        .red(red),
        .green(green),
        .blue(blue),
        .fail_count(fail_count),
        .pending(pending),
        .pixel_total(pixel_total),
        .escaped_total(escaped_total)
    );

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    wire moved = (in_valid && !in_stall) || (out_valid && !out_stall)
                 || (cfg_valid && cfg_ready);

    always @(posedge clk)
    begin
        if (!rst_n || moved)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic request_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] rw);
        @(negedge clk);
        // each cycle the sender may hold back before raising the request
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        column   <= col;
        row      <= rw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_pixels();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_plane(input logic [31:0] o_re, input logic [31:0] o_im,
                             input logic [23:0] s_re, input logic [23:0] s_im,
                             input logic [11:0] lim, input logic [6:0] rad);
        drain_pixels();
        write_reg(REG_ORIGIN_RE, o_re);
        write_reg(REG_ORIGIN_IM, o_im);
        write_reg(REG_STEP_RE, 32'(s_re));
        write_reg(REG_STEP_IM, 32'(s_im));
        write_reg(REG_ITER_LIMIT, 32'(lim));
        write_reg(REG_RADIUS_SQ, 32'(rad));
        plane_changes++;
    endtask

    initial
    begin
        logic [31:0] o_re;
        logic [31:0] o_im;
        logic [23:0] s_re;
        logic [23:0] s_im;
        logic [11:0] lim;
        logic [6:0]  rad;
        bit          wide;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset view: corners, alternating bit patterns and a point inside the set
        request_pixel(10'd0, 10'd0);
        request_pixel(10'd1023, 10'd1023);
        request_pixel(10'd0, 10'd1023);
        request_pixel(10'd1023, 10'd0);
        request_pixel(10'h2AA, 10'h155);
        request_pixel(10'h155, 10'h2AA);
        request_pixel(10'd400, 10'd400);

        drain_pixels();
        write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_B, $urandom());
        request_pixel(10'd1, 10'd2);

        // no iterations at all
        set_plane(32'hFE00_0000, 32'hFE80_0000, 24'd62915, 24'd62915, 12'd0, 7'd100);
        request_pixel(10'd300, 10'd300);

        // zero radius: only z = 0 stays
        set_plane(32'h0, 32'h0, 24'd1, 24'd1, 12'd16, 7'd0);
        request_pixel(10'd0, 10'd0);
        request_pixel(10'd1, 10'd0);
        request_pixel(10'd0, 10'd1);

        // c formed past the top of the range saturates
        set_plane(32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 24'hFF_FFFF, 12'd12, 7'd127);
        request_pixel(10'd1023, 10'd0);
        request_pixel(10'd0, 10'd1023);

        // first step overflows the real part, then the imaginary part
        set_plane(32'h0B33_3333, 32'h0, 24'd0, 24'd0, 12'd8, 7'd127);
        request_pixel(10'd5, 10'd5);
        set_plane(32'h07E6_6666, 32'h07E6_6666, 24'd0, 24'd0, 12'd8, 7'd127);
        request_pixel(10'd9, 10'd9);

        // longest orbit the limit allows
        set_plane(32'h0, 32'h0, 24'd0, 24'd0, 12'd4095, 7'd4);
        request_pixel(10'd0, 10'd0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wide = (phase % 3 == 2);
            if (wide)
            begin
                o_re = $urandom();
                o_im = $urandom();
                s_re = 24'($urandom_range(0, 24'hFF_FFFF));
                s_im = 24'($urandom_range(0, 24'hFF_FFFF));
            end
            else
            begin
                // window around the set, roughly -2.5..0.5 by -1.5..1.5 at the origin
                o_re = $urandom_range(0, 32'h0300_0000) - 32'h0280_0000;
                o_im = $urandom_range(0, 32'h0300_0000) - 32'h0180_0000;
                s_re = 24'($urandom_range(1, 24'h00_FFFF));
                s_im = 24'($urandom_range(1, 24'h00_FFFF));
            end
            case (phase)
                0:       lim = 12'd1;
                1:       lim = 12'd256;
                2:       lim = 12'd4095;
                default: lim = 12'($urandom_range(2, 64));
            endcase
            case (phase)
                3:       rad = 7'd127;
                4:       rad = 7'd1;
                5:       rad = 7'd0;
                default: rad = 7'($urandom_range(1, 127));
            endcase
            set_plane(o_re, o_im, s_re, s_im, lim, rad);

            // receiver-heavy stalling, then sender-heavy idling, then flat out
            if (phase < 5)
            begin
                send_idle_pct = 38;
                stall_pct     = 78;
            end
            else if (phase < 9)
            begin
                send_idle_pct = 78;
                stall_pct     = 38;
            end
            else
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end

            repeat (PIXELS_PER_SET)
                request_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
        end

        drain_pixels();
        repeat (8) @(posedge clk);

        $display("escape-time run: %0d pixels, %0d escaped, over %0d register settings",
                 pixel_total, escaped_total, plane_changes);
        $display("covered zero limit, zero radius, coordinate and orbit saturation, spare indexes");
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/mbet_pkg.sv
design/mbet_regs.sv
design/mbet_ctrl.sv
design/mbet_dpath.sv
design/mandelbrot_escape_time_core.sv
dv/mandelbrot_escape_time_checker.sv
dv/mandelbrot_escape_time_core_tb.sv
